[hdl/ucrf_pkg.sv]
`timescale 1ns / 1ps
package ucrf_pkg;

  // Operation codes on the request channel
  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_BURST = 2'd1,
    OP_GETC  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  // Command kinds held in the queue between front and back
  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_BURST = 2'd1,
    CMD_GETC  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
    logic [6:0] len;
  } cmd_t;

  localparam int unsigned CmpW = 9;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] NoByte = 8'h00;

endpackage

[hdl/ucrf_if.sv]
`timescale 1ns / 1ps
interface ucrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [6:0] burst_length;

  modport source (output valid, operation, rx_byte, burst_length, input ready);
  modport sink   (input valid, operation, rx_byte, burst_length, output ready);
endinterface

interface ucrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic [6:0] delivered_count;
  logic [7:0] fill_level;

  modport source (output valid, data_byte, byte_valid, last, delivered_count, fill_level,
                  input ready);
  modport sink   (input valid, data_byte, byte_valid, last, delivered_count, fill_level,
                  output ready);
endinterface

[hdl/ucrf_ram.sv]
`timescale 1ns / 1ps
module ucrf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       re_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/ucrf_front.sv]
`timescale 1ns / 1ps
module ucrf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ucrf_in_if.sink       req_i,
  output ucrf_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import ucrf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       keep;
  cmd_t       cmd_new;
  logic       push, pop;

  // classify: reserved code is taken and dropped
  always_comb begin
    keep         = 1'b1;
    cmd_new.data = req_i.rx_byte;
    cmd_new.len  = req_i.burst_length;
    cmd_new.kind = CMD_PUSH;
    case (op_e'(req_i.operation))
      OP_RECV:  cmd_new.kind = CMD_PUSH;
      OP_BURST: cmd_new.kind = CMD_BURST;
      OP_GETC:  cmd_new.kind = CMD_GETC;
      default:  keep = 1'b0;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_new;
    end
  end

endmodule

[hdl/ucrf_back.sv]
`timescale 1ns / 1ps
module ucrf_back #(
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ucrf_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  ucrf_out_if.source     rsp_o
);
  import ucrf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] count_q, count_d;
  logic [6:0]    n_q, n_d;
  logic [6:0]    done_q, done_d;
  logic          getc_q, getc_d;

  logic          out_vld_q, out_vld_d;
  logic [7:0]    out_data_q, out_data_d;
  logic          out_bv_q, out_bv_d;
  logic          out_last_q, out_last_d;
  logic [6:0]    out_cnt_q, out_cnt_d;
  logic [7:0]    out_fill_q, out_fill_d;
  logic          out_load;

  logic          we, re;
  logic [7:0]    rdata;
  logic          out_free;
  logic [6:0]    len_clamp;
  logic [6:0]    n_new;
  logic          is_last;
  logic [7:0]    byte_fix;

  ucrf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_ptr_q),
    .wdata_i (cmd_i.data),
    .re_i    (re),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign out_free  = !out_vld_q || rsp_o.ready;
  assign len_clamp = (cmd_i.len > 7'(MAX_BURST)) ? 7'(MAX_BURST) : cmd_i.len;
  assign is_last   = ((done_q + 7'd1) == n_q);
  assign byte_fix  = (getc_q && rdata == CharCr) ? CharLf : rdata;

  always_comb begin
    if (cmd_i.kind == CMD_GETC) begin
      n_new = 7'd1;
    end else if (CmpW'(count_q) < CmpW'(len_clamp)) begin
      n_new = 7'(count_q);
    end else begin
      n_new = len_clamp;
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    count_d     = count_q;
    n_d         = n_q;
    done_d      = done_q;
    getc_d      = getc_q;
    cmd_ready_o = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    out_load    = 1'b0;
    out_data_d  = out_data_q;
    out_bv_d    = out_bv_q;
    out_last_d  = out_last_q;
    out_cnt_d   = out_cnt_q;
    out_fill_d  = out_fill_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == CMD_PUSH) begin
            cmd_ready_o = 1'b1;
            // drop the byte when full
            if (count_q != PW'(DEPTH - 1)) begin
              we       = 1'b1;
              wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
              count_d  = count_q + 1'b1;
            end
          end else if (count_q == '0 || n_new == 7'd0) begin
            // nothing to pop: single invalid result
            cmd_ready_o = out_free;
            if (out_free) begin
              out_load   = 1'b1;
              out_data_d = NoByte;
              out_bv_d   = 1'b0;
              out_last_d = 1'b1;
              out_cnt_d  = 7'd0;
              out_fill_d = 8'(count_q);
            end
          end else begin
            cmd_ready_o = 1'b1;
            n_d         = n_new;
            done_d      = 7'd0;
            getc_d      = (cmd_i.kind == CMD_GETC);
            state_d     = S_READ;
          end
        end
      end
      S_READ: begin
        re       = 1'b1;
        rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
        count_d  = count_q - 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = byte_fix;
          out_bv_d   = 1'b1;
          out_last_d = is_last;
          out_cnt_d  = done_q + 7'd1;
          out_fill_d = 8'(count_q);
          done_d     = done_q + 7'd1;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            // advance to the next byte while this one goes out
            re       = 1'b1;
            rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      count_q   <= '0;
      n_q       <= 7'd0;
      done_q    <= 7'd0;
      getc_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      count_q   <= count_d;
      n_q       <= n_d;
      done_q    <= done_d;
      getc_q    <= getc_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_bv_q   <= out_bv_d;
    out_last_q <= out_last_d;
    out_cnt_q  <= out_cnt_d;
    out_fill_q <= out_fill_d;
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.data_byte       = out_data_q;
  assign rsp_o.byte_valid      = out_bv_q;
  assign rsp_o.last            = out_last_q;
  assign rsp_o.delivered_count = out_cnt_q;
  assign rsp_o.fill_level      = out_fill_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PW'(DEPTH - 1))
    else $error("fill count beyond capacity");

  a_read_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_LOAD)
    else $error("read issue not followed by load");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not lower the fill count");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_bv_q |-> out_last_q && out_cnt_q == 7'd0)
    else $error("invalid result not final");
`endif

endmodule

[hdl/uart_receive_ring_fifo_unit.sv]
`timescale 1ns / 1ps
// Receive: accepted at one per cycle while the queue has room; the back end then stores the byte.
// Burst read or get char: the back end reads the store (S_READ), then loads the output register
//   (S_LOAD), then one byte per cycle while results are taken; an empty ring or a zero-length
//   burst answers with a single invalid result. Commands run one at a time in the back end.
// The byte store has a registered read port; commands pass through a queue to the back end.
// Reset (rst_ni low, asynchronous) empties the ring and the command queue; store contents
//   stay undefined and need no clearing pass.
module uart_receive_ring_fifo_unit #(
  parameter int unsigned DEPTH     = 128,
  parameter int unsigned MAX_BURST = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ucrf_in_if.sink    req_i,
  ucrf_out_if.source rsp_o
);
  import ucrf_pkg::*;

  // Command handoff between the request front end and the ring back end
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // Front end: take each request, drop the reserved opcode, queue the rest
  ucrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready)
  );

  // Back end: own the ring pointers and the byte store, and stream results
  // through a single output register; a waiting result stalls the back end,
  // and the command queue then fills up.
  ucrf_back #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import ucrf_pkg::*;

  localparam int unsigned RingDepth   = 128;
  localparam int unsigned BurstCap    = 64;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 20;

  // One popped-byte result as the block reports it
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [6:0] delivered_count;
    logic [7:0] fill_level;
  } rx_result_t;

  logic clk_i;
  logic rst_ni;

  ucrf_in_if  req_if ();
  ucrf_out_if rsp_if ();

  uart_receive_ring_fifo_unit #(
    .DEPTH     (RingDepth),
    .MAX_BURST (BurstCap)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the ring, advanced as each request is accepted
  logic [7:0]  shadow_ring [RingDepth];
  int unsigned shadow_rd;
  int unsigned shadow_wr;
  rx_result_t  expected_results [$];

  int          error_count;
  int unsigned cycle_count;
  int unsigned sink_stall_left;
  bit          sender_quiet;
  bit          sink_quiet;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 94) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_rx_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return CharCr;
    if (roll < 17) return CharLf;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short bursts, some zero and some past the clamp
  function automatic logic [6:0] pick_burst_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return 7'd0;
    if (roll < 65) return 7'($urandom_range(1, 16));
    if (roll < 88) return 7'($urandom_range(17, BurstCap));
    return 7'($urandom_range(BurstCap + 1, 127));
  endfunction

  function automatic int unsigned ring_fill();
    return (shadow_wr + RingDepth - shadow_rd) % RingDepth;
  endfunction

  // Apply one accepted request to the shadow ring and queue its results
  task automatic predict_ring_request(input op_e op, input logic [7:0] rx_byte,
                                      input logic [6:0] burst_length);
    int unsigned fill;
    int unsigned want;
    int unsigned n;
    int unsigned k;
    rx_result_t  res;
    fill = ring_fill();
    want = burst_length;
    res  = '0;
    case (op)
      OP_RECV: begin
        // Drop the byte when the ring already holds DEPTH-1
        if (fill != RingDepth - 1) begin
          shadow_ring[shadow_wr] = rx_byte;
          shadow_wr = (shadow_wr + 1) % RingDepth;
        end
      end
      OP_BURST: begin
        if (want > BurstCap) want = BurstCap;
        if (fill == 0 || want == 0) begin
          res.data_byte  = NoByte;
          res.last       = 1'b1;
          res.fill_level = 8'(fill);
          expected_results.push_back(res);
        end else begin
          n = (fill < want) ? fill : want;
          for (k = 0; k < n; k++) begin
            res.data_byte       = shadow_ring[shadow_rd];
            shadow_rd           = (shadow_rd + 1) % RingDepth;
            res.byte_valid      = 1'b1;
            res.last            = (k + 1 == n);
            res.delivered_count = 7'(k + 1);
            res.fill_level      = 8'(ring_fill());
            expected_results.push_back(res);
          end
        end
      end
      OP_GETC: begin
        res.last = 1'b1;
        if (fill != 0) begin
          res.data_byte = shadow_ring[shadow_rd];
          shadow_rd     = (shadow_rd + 1) % RingDepth;
          // Turn carriage return into line feed
          if (res.data_byte == CharCr) res.data_byte = CharLf;
          res.byte_valid      = 1'b1;
          res.delivered_count = 7'd1;
          res.fill_level      = 8'(ring_fill());
        end
        expected_results.push_back(res);
      end
      default: ; // reserved code: no state change, no result
    endcase
  endtask

  // Hold the request until accepted; valid stays high afterward so that a
  // back-to-back request needs no second assignment in the same step
  task automatic send_request(input op_e op, input logic [7:0] rx_byte,
                              input logic [6:0] burst_length);
    int unsigned gap;
    gap = (!sender_quiet && $urandom_range(0, 99) < 35) ? idle_length() : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.operation    <= op;
    req_if.rx_byte      <= rx_byte;
    req_if.burst_length <= burst_length;
    do @(posedge clk_i); while (!req_if.ready);
    predict_ring_request(op, rx_byte, burst_length);
  endtask

  task automatic wait_for_drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Result sink: random stalls, with quiet stretches
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stall_left != 0) begin
        sink_stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 99) < 25) begin
        sink_stall_left = idle_length() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    rx_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result data_byte %02h", rsp_if.data_byte));
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.data_byte !== want.data_byte)
          flag_mismatch($sformatf("data_byte got %02h want %02h",
                                  rsp_if.data_byte, want.data_byte));
        if (rsp_if.byte_valid !== want.byte_valid)
          flag_mismatch($sformatf("byte_valid got %0b want %0b",
                                  rsp_if.byte_valid, want.byte_valid));
        if (rsp_if.last !== want.last)
          flag_mismatch($sformatf("last got %0b want %0b", rsp_if.last, want.last));
        if (rsp_if.delivered_count !== want.delivered_count)
          flag_mismatch($sformatf("delivered_count got %0d want %0d",
                                  rsp_if.delivered_count, want.delivered_count));
        if (rsp_if.fill_level !== want.fill_level)
          flag_mismatch($sformatf("fill_level got %0d want %0d",
                                  rsp_if.fill_level, want.fill_level));
      end
    end
  end

  // Reads on an empty ring, zero-length burst, and the reserved code
  task automatic test_empty_ring();
    send_request(OP_BURST, 8'h00, 7'd1);
    send_request(OP_BURST, 8'hFF, 7'd64);
    send_request(OP_GETC, 8'h00, 7'd0);
    send_request(OP_BURST, 8'h00, 7'd0);
    send_request(OP_RSVD, 8'h5A, 7'd127);
    send_request(OP_GETC, 8'hFF, 7'd127);
  endtask

  // Byte extremes, CR conversion on get char only, long bursts on a short ring
  task automatic test_directed_ops();
    send_request(OP_RECV, 8'h00, 7'd0);
    send_request(OP_RECV, 8'hFF, 7'd127);
    send_request(OP_RECV, CharCr, 7'd1);
    send_request(OP_RECV, CharCr, 7'd64);
    send_request(OP_RECV, 8'h55, 7'd0);
    send_request(OP_RECV, 8'hAA, 7'd0);
    send_request(OP_RECV, CharLf, 7'd0);
    send_request(OP_RECV, 8'h80, 7'd0);
    send_request(OP_BURST, 8'h00, 7'd0);
    send_request(OP_GETC, 8'h00, 7'd0);
    send_request(OP_GETC, 8'h00, 7'd0);
    send_request(OP_GETC, 8'h00, 7'd0);
    send_request(OP_BURST, 8'h00, 7'd1);
    send_request(OP_RSVD, 8'hFF, 7'd127);
    send_request(OP_BURST, 8'h00, 7'd127);
    send_request(OP_BURST, 8'h00, 7'd64);
  endtask

  // Fill the ring to DEPTH-1, push into a full ring, then drain with
  // clamped bursts; the pointers wrap on the way
  task automatic test_full_ring();
    int unsigned i;
    wait_for_drain();
    sender_quiet = 1'b1;
    sink_quiet   = 1'b1;
    for (i = 0; i < RingDepth + 5; i++) begin
      if (i == 60) sender_quiet = 1'b0;
      send_request(OP_RECV, pick_rx_byte(), 7'($urandom_range(0, 127)));
    end
    sink_quiet = 1'b0;
    send_request(OP_GETC, 8'h00, 7'd0);
    send_request(OP_RECV, pick_rx_byte(), 7'd0);
    send_request(OP_RECV, pick_rx_byte(), 7'd0);
    send_request(OP_BURST, 8'h00, 7'd127);
    send_request(OP_BURST, 8'h00, 7'd64);
    send_request(OP_BURST, 8'h00, 7'd64);
    send_request(OP_BURST, 8'h00, 7'd5);
  endtask

  // Segments of mixed traffic, each with its own push bias and idling
  task automatic test_random_traffic();
    int unsigned seg;
    int unsigned counted;
    int unsigned push_weight;
    int unsigned roll;
    op_e         op;
    for (seg = 0; seg < 5; seg++) begin
      case ($urandom_range(0, 2))
        0: push_weight = 30;
        1: push_weight = 55;
        default: push_weight = 80;
      endcase
      sender_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);
      counted = 0;
      while (counted < 44) begin
        roll = $urandom_range(0, 99);
        if (roll < push_weight) op = OP_RECV;
        else if (roll < push_weight + (100 - push_weight) / 2) op = OP_BURST;
        else if (roll < 95) op = OP_GETC;
        else op = OP_RSVD;
        if (op != OP_RSVD) counted++;
        send_request(op, pick_rx_byte(),
                     (op == OP_BURST) ? pick_burst_length() : 7'($urandom_range(0, 127)));
      end
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  initial begin
    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.operation    = OP_RECV;
    req_if.rx_byte      = 8'h00;
    req_if.burst_length = 7'd0;
    shadow_rd           = 0;
    shadow_wr           = 0;
    error_count         = 0;
    cycle_count         = 0;
    sink_stall_left     = 0;
    sender_quiet        = 1'b0;
    sink_quiet          = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_ring();
    test_directed_ops();
    test_full_ring();
    test_random_traffic();

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
